[design/aalu_pkg.sv]
package aalu_pkg;

  // Operation codes carried in the kind field
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBB  = 5'd3;
  localparam logic [4:0] OP_ANA  = 5'd4;
  localparam logic [4:0] OP_XRA  = 5'd5;
  localparam logic [4:0] OP_ORA  = 5'd6;
  localparam logic [4:0] OP_CMP  = 5'd7;
  localparam logic [4:0] OP_INR  = 5'd8;
  localparam logic [4:0] OP_DCR  = 5'd9;
  localparam logic [4:0] OP_RLC  = 5'd10;
  localparam logic [4:0] OP_RRC  = 5'd11;
  localparam logic [4:0] OP_RAL  = 5'd12;
  localparam logic [4:0] OP_RAR  = 5'd13;
  localparam logic [4:0] OP_DAA  = 5'd14;
  localparam logic [4:0] OP_CMA  = 5'd15;
  localparam logic [4:0] OP_STC  = 5'd16;
  localparam logic [4:0] OP_CMC  = 5'd17;
  localparam logic [4:0] OP_LOAD = 5'd18;

  // Decimal adjust constants
  localparam logic [3:0] DAA_LOW_LIMIT  = 4'd9;
  localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] operand;
  } in_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] result_byte;
    logic       sign_flag;
    logic       zero_flag;
    logic       aux_carry_flag;
    logic       parity_flag;
    logic       carry_flag;
  } out_t;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

endpackage

[design/accumulator_alu_with_flags_unit.sv]
// A transaction passes through the input register, then the result register.
// One transaction per cycle while out_stall is low; the 8-bit adder and flag logic
// sit between input and result registers, which also update accumulator and flags.
// Reset (rst_n low, synchronous): accumulator and flags cleared, both stages emptied.
module accumulator_alu_with_flags_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  aalu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output aalu_pkg::out_t out_data
);
  import aalu_pkg::*;

  logic   in_valid_r;
  in_t    in_data_r;
  logic   out_valid_r;
  out_t   out_data_r;
  logic [7:0] acc_r;
  flags_t flags_r;

  logic   advance;
  logic [7:0] acc_nxt;
  logic [7:0] res_nxt;
  flags_t flags_nxt;

  // Adder shared by add, subtract and compare
  logic [7:0] a, b, b_add;
  logic       cin;
  logic [8:0] sum;
  logic [4:0] low_sum;
  logic       is_sub;

  // Decimal adjust
  logic [7:0] daa_adj;
  logic       daa_cy;
  logic [7:0] daa_res;
  logic [4:0] daa_low;

  // Step results
  logic [7:0] inr_res, dcr_res;

  function automatic flags_t szp(input logic [7:0] r, input logic ac, input logic cy);
    flags_t f;
    f.s  = r[7];
    f.z  = (r == 8'd0);
    f.p  = ~^r;
    f.ac = ac;
    f.cy = cy;
    return f;
  endfunction

  // Handshake: the input stage moves on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign a = acc_r;
  assign b = in_data_r.operand;

  // Adder operand selection
  always_comb begin
    is_sub = 1'b0;
    b_add  = b;
    cin    = 1'b0;
    unique case (in_data_r.kind)
      OP_ADC: cin = flags_r.cy;
      OP_SUB, OP_CMP: begin
        is_sub = 1'b1;
        b_add  = ~b;
        cin    = 1'b1;
      end
      OP_SBB: begin
        is_sub = 1'b1;
        b_add  = ~b;
        cin    = ~flags_r.cy;
      end
      default: ;
    endcase
  end

  assign sum     = {1'b0, a} + {1'b0, b_add} + {8'd0, cin};
  assign low_sum = {1'b0, a[3:0]} + {1'b0, b_add[3:0]} + {4'd0, cin};

  // Decimal adjust terms
  always_comb begin
    daa_adj = 8'd0;
    daa_cy  = flags_r.cy;
    if ((a[3:0] > DAA_LOW_LIMIT) || flags_r.ac) begin
      daa_adj = daa_adj | DAA_LOW_ADJ;
    end
    if ((a > DAA_HIGH_LIMIT) || flags_r.cy) begin
      daa_adj = daa_adj | DAA_HIGH_ADJ;
      daa_cy  = 1'b1;
    end
  end

  assign daa_res = a + daa_adj;
  assign daa_low = {1'b0, a[3:0]} + {1'b0, daa_adj[3:0]};
  assign inr_res = b + 8'd1;
  assign dcr_res = b - 8'd1;

  // Operation result and flag update
  always_comb begin
    acc_nxt   = acc_r;
    res_nxt   = acc_r;
    flags_nxt = flags_r;
    unique case (in_data_r.kind)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
        acc_nxt   = sum[7:0];
        res_nxt   = sum[7:0];
        flags_nxt = szp(sum[7:0], low_sum[4], sum[8] ^ is_sub);
      end
      OP_CMP: begin
        res_nxt   = sum[7:0];
        flags_nxt = szp(sum[7:0], low_sum[4], sum[8] ^ is_sub);
      end
      OP_ANA: begin
        acc_nxt   = a & b;
        res_nxt   = a & b;
        flags_nxt = szp(a & b, a[3] | b[3], 1'b0);
      end
      OP_XRA: begin
        acc_nxt   = a ^ b;
        res_nxt   = a ^ b;
        flags_nxt = szp(a ^ b, 1'b0, 1'b0);
      end
      OP_ORA: begin
        acc_nxt   = a | b;
        res_nxt   = a | b;
        flags_nxt = szp(a | b, 1'b0, 1'b0);
      end
      OP_INR: begin
        res_nxt   = inr_res;
        flags_nxt = szp(inr_res, b[3:0] == 4'hf, flags_r.cy);
      end
      OP_DCR: begin
        res_nxt   = dcr_res;
        flags_nxt = szp(dcr_res, b[3:0] != 4'h0, flags_r.cy);
      end
      OP_RLC: begin
        acc_nxt      = {a[6:0], a[7]};
        res_nxt      = {a[6:0], a[7]};
        flags_nxt.cy = a[7];
      end
      OP_RRC: begin
        acc_nxt      = {a[0], a[7:1]};
        res_nxt      = {a[0], a[7:1]};
        flags_nxt.cy = a[0];
      end
      OP_RAL: begin
        acc_nxt      = {a[6:0], flags_r.cy};
        res_nxt      = {a[6:0], flags_r.cy};
        flags_nxt.cy = a[7];
      end
      OP_RAR: begin
        acc_nxt      = {flags_r.cy, a[7:1]};
        res_nxt      = {flags_r.cy, a[7:1]};
        flags_nxt.cy = a[0];
      end
      OP_DAA: begin
        acc_nxt   = daa_res;
        res_nxt   = daa_res;
        flags_nxt = szp(daa_res, daa_low[4], daa_cy);
      end
      OP_CMA: begin
        acc_nxt = ~a;
        res_nxt = ~a;
      end
      OP_STC:  flags_nxt.cy = 1'b1;
      OP_CMC:  flags_nxt.cy = ~flags_r.cy;
      OP_LOAD: begin
        acc_nxt = b;
        res_nxt = b;
      end
      default: ;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 8'd0;
      flags_r     <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        flags_r     <= flags_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.acc_out        <= acc_nxt;
      out_data_r.result_byte    <= res_nxt;
      out_data_r.sign_flag      <= flags_nxt.s;
      out_data_r.zero_flag      <= flags_nxt.z;
      out_data_r.aux_carry_flag <= flags_nxt.ac;
      out_data_r.parity_flag    <= flags_nxt.p;
      out_data_r.carry_flag     <= flags_nxt.cy;
    end
  end

`ifndef ASSERT_OFF
  // Stall only while the input register holds a transaction
  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with empty input register");

  // A transaction that moves on always lands in the result register
  a_advance_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced transaction lost");

  // Shown accumulator and carry track the kept state
  a_acc_track : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.acc_out == acc_r) && (out_data_r.carry_flag == flags_r.cy))
    else $error("result disagrees with kept accumulator or carry");
`endif

endmodule
